FILE: src/rmma_pkg.sv
// Shared constants for the running metric moving-average block.
// No dependencies; imported by every module under src.
package rmma_pkg;

    localparam int WINDOW_DEF   = 5;
    localparam int CAD_W        = 8;
    localparam int CONTACT_W    = 16;
    localparam int STRIKE_W     = 8;
    localparam int CMD_W        = 2;
    localparam int CAD_SHOWN_W  = 9;
    localparam int ST_SHOWN_W   = 12;
    localparam int STRIKE_SCALE = 10;

    localparam logic [CMD_W-1:0] CMD_CADENCE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CONTACT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd2;

    typedef struct packed {
        logic cad;
        logic custom;
        logic ready;
    } fresh_t;

endpackage

FILE: src/rmma_cell.sv
// One stage of a sample delay line: holds a sample and passes it on.
// Depends on rmma_pkg.
module rmma_cell
    import rmma_pkg::*;
#(
    parameter int W = CAD_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         shift_en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sample_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
        end else if (shift_en) begin
            sample_reg <= din;
        end
    end

    assign dout = sample_reg;

endmodule

FILE: src/rmma_window.sv
// Window of the last WINDOW samples as a chain of cells, plus running sum.
// Depends on rmma_pkg and rmma_cell.
module rmma_window
    import rmma_pkg::*;
#(
    parameter int W      = CAD_W,
    parameter int WINDOW = WINDOW_DEF,
    parameter int TW     = W + $clog2(WINDOW + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          shift_en,
    input  logic [W-1:0]  sample,
    output logic [TW-1:0] total
);

    logic [W-1:0]  tap [WINDOW];
    logic [TW-1:0] total_reg;
    logic [TW-1:0] total_next;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++) begin : g_cell
            if (i == 0) begin : g_head
                rmma_cell #(.W(W)) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .shift_en(shift_en),
                    .din     (sample),
                    .dout    (tap[i])
                );
            end else begin : g_body
                rmma_cell #(.W(W)) u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .shift_en(shift_en),
                    .din     (tap[i-1]),
                    .dout    (tap[i])
                );
            end
        end
    endgenerate

    // Sample leaving the window is the last tap (zero until the line fills).
    assign total_next = total_reg + TW'(sample) - TW'(tap[WINDOW-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (shift_en) begin
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

FILE: src/rmma_div.sv
// Restoring divider, one quotient bit per cycle, shared by all averages.
// Depends on rmma_pkg.
module rmma_div
    import rmma_pkg::*;
#(
    parameter int NW = 19,
    parameter int DW = 3
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits   = (rem_sh >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/running_metric_moving_average.sv
// Moving averages of cadence, contact time and strike over WINDOW samples.
// Depends on rmma_pkg, rmma_window, rmma_div.
//
// Input channel s_*: one transaction per command. s_tuser carries the
// command (cadence sample, contact/strike sample, take update); s_tdata
// carries the samples. Every command returns exactly one result on m_*:
// the held averages plus the update_ready flag (set only on a take that
// found both groups fresh, which also clears the flags).
// Each metric keeps its window in a chain of delay cells with a running
// sum; averages come from one shared restoring divider that produces one
// quotient bit per cycle over DIV_W = 16 + clog2(WINDOW+1) bits (19 at
// WINDOW = 5).
// A take, a zero sample or an unused command goes straight from idle to the
// done state; a cadence sample first runs one division, a contact/strike
// sample two in turn (contact time, then strike).
// One item is worked on at a time; s_tready is high only while idle.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled receiver blocks only the finish of that next item.
// Synchronous reset (aresetn low) empties all windows, zeros the averages
// and flags, and drops any pending result.
module running_metric_moving_average
    import rmma_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] cadence_sample, [23:8] contact_time_sample, [31:24] strike_sample
    input  logic [31:0] s_tdata,
    // [1:0] command
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [8:0] cadence_shown, [24:9] contact_time_shown, [36:25] strike_shown,
    // [37] update_ready, [39:38] zero
    output logic [39:0] m_tdata
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int CAD_TW = CAD_W + FILL_W;
    localparam int CT_TW  = CONTACT_W + FILL_W;
    localparam int ST_TW  = STRIKE_W + FILL_W;
    localparam int DIV_W  = CT_TW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CAD_GO  = 3'd1;
    localparam logic [2:0] S_CAD_WT  = 3'd2;
    localparam logic [2:0] S_CT_GO   = 3'd3;
    localparam logic [2:0] S_CT_WT   = 3'd4;
    localparam logic [2:0] S_ST_GO   = 3'd5;
    localparam logic [2:0] S_ST_WT   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [CMD_W-1:0]     cmd;
    logic [CAD_W-1:0]     cad_in;
    logic [CONTACT_W-1:0] ct_in;
    logic [STRIKE_W-1:0]  st_in;

    logic [2:0]            state_reg, state_next;
    logic [FILL_W-1:0]     cad_fill_reg, cad_fill_next;
    logic [FILL_W-1:0]     cust_fill_reg, cust_fill_next;
    fresh_t                fresh_reg, fresh_next;
    logic                  upd_reg, upd_next;
    logic [CAD_SHOWN_W-1:0] shown_cad_reg, shown_cad_next;
    logic [CONTACT_W-1:0]  shown_ct_reg, shown_ct_next;
    logic [ST_SHOWN_W-1:0] shown_st_reg, shown_st_next;
    logic                  m_valid_reg, m_valid_next;
    logic [39:0]           m_data_reg, m_data_next;

    logic                  accept;
    logic                  cad_shift;
    logic                  cust_shift;
    logic [CAD_TW-1:0]     cad_total;
    logic [CT_TW-1:0]      ct_total;
    logic [ST_TW-1:0]      st_total;

    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [FILL_W-1:0]     div_divisor;
    logic                  div_done;
    logic [DIV_W-1:0]      div_quo;

    assign cmd    = s_tuser;
    assign cad_in = s_tdata[7:0];
    assign ct_in  = s_tdata[23:8];
    assign st_in  = s_tdata[31:24];

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign cad_shift  = accept && (cmd == CMD_CADENCE) && (cad_in != '0);
    assign cust_shift = accept && (cmd == CMD_CONTACT) && (ct_in != '0);

    rmma_window #(.W(CAD_W), .WINDOW(WINDOW), .TW(CAD_TW)) u_cad_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift_en(cad_shift),
        .sample  (cad_in),
        .total   (cad_total)
    );

    rmma_window #(.W(CONTACT_W), .WINDOW(WINDOW), .TW(CT_TW)) u_ct_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift_en(cust_shift),
        .sample  (ct_in),
        .total   (ct_total)
    );

    rmma_window #(.W(STRIKE_W), .WINDOW(WINDOW), .TW(ST_TW)) u_st_win (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift_en(cust_shift),
        .sample  (st_in),
        .total   (st_total)
    );

    rmma_div #(.NW(DIV_W), .DW(FILL_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_quo)
    );

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIV_W'(cad_total);
        div_divisor  = cad_fill_reg;
        case (state_reg)
            S_CAD_GO: begin
                div_start = 1'b1;
            end
            S_CT_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(ct_total);
                div_divisor  = cust_fill_reg;
            end
            S_ST_GO: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(st_total) * DIV_W'(STRIKE_SCALE);
                div_divisor  = cust_fill_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        cad_fill_next  = cad_fill_reg;
        cust_fill_next = cust_fill_reg;
        fresh_next     = fresh_reg;
        upd_next       = upd_reg;
        shown_cad_next = shown_cad_reg;
        shown_ct_next  = shown_ct_reg;
        shown_st_next  = shown_st_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    upd_next   = 1'b0;
                    state_next = S_DONE;
                    case (cmd)
                        CMD_CADENCE: begin
                            if (cad_shift) begin
                                fresh_next.cad = 1'b1;
                                if (cad_fill_reg != FILL_W'(WINDOW)) begin
                                    cad_fill_next = cad_fill_reg + 1'b1;
                                end
                                state_next = S_CAD_GO;
                            end
                            if ((cad_shift || fresh_reg.cad) && fresh_reg.custom) begin
                                fresh_next.ready = 1'b1;
                            end
                        end
                        CMD_CONTACT: begin
                            if (cust_shift) begin
                                fresh_next.custom = 1'b1;
                                if (cust_fill_reg != FILL_W'(WINDOW)) begin
                                    cust_fill_next = cust_fill_reg + 1'b1;
                                end
                                state_next = S_CT_GO;
                            end
                        end
                        CMD_TAKE: begin
                            if (fresh_reg.ready) begin
                                fresh_next = '0;
                                upd_next   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CAD_GO: state_next = S_CAD_WT;
            S_CAD_WT: begin
                if (div_done) begin
                    shown_cad_next = {div_quo[CAD_W-1:0], 1'b0};
                    state_next     = S_DONE;
                end
            end
            S_CT_GO: state_next = S_CT_WT;
            S_CT_WT: begin
                if (div_done) begin
                    shown_ct_next = div_quo[CONTACT_W-1:0];
                    state_next    = S_ST_GO;
                end
            end
            S_ST_GO: state_next = S_ST_WT;
            S_ST_WT: begin
                if (div_done) begin
                    shown_st_next = div_quo[ST_SHOWN_W-1:0];
                    state_next    = S_DONE;
                end
            end
            S_DONE: begin
                // load the output register once the previous transaction left
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, upd_reg, shown_st_reg, shown_ct_reg,
                                    shown_cad_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cad_fill_reg  <= '0;
            cust_fill_reg <= '0;
            fresh_reg     <= '0;
            upd_reg       <= 1'b0;
            shown_cad_reg <= '0;
            shown_ct_reg  <= '0;
            shown_st_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cad_fill_reg  <= cad_fill_next;
            cust_fill_reg <= cust_fill_next;
            fresh_reg     <= fresh_next;
            upd_reg       <= upd_next;
            shown_cad_reg <= shown_cad_next;
            shown_ct_reg  <= shown_ct_next;
            shown_st_reg  <= shown_st_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
